// ===== rtl/sidrw_pkg.sv =====
// Shared types and constants for the signed integer to digit-register formatter.
// No dependencies; used by sidrw_cell and the top level.
package sidrw_pkg;

  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned VALUE_W    = 16;

  localparam logic [3:0] CODE_ZERO  = 4'h0;
  localparam logic [3:0] CODE_MINUS = 4'hA;
  localparam logic [3:0] CODE_BLANK = 4'hF;
  localparam logic [3:0] FIRST_ADDR = 4'h1;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic clear;      // load zero into every cell
    logic bin_shift;  // double-dabble step: add 3 if >= 5, shift one bit in
    logic dig_shift;  // move each digit one cell toward the top
  } cell_ctrl_t;

endpackage

// ===== rtl/sidrw_cell.sv =====
// One decimal digit cell of the conversion chain.
// Depends on sidrw_pkg (cell_ctrl_t, CODE_ZERO).
module sidrw_cell (
  input  logic                  clk,
  input  sidrw_pkg::cell_ctrl_t ctrl,
  input  logic                  bit_in,
  input  logic [3:0]            digit_in,
  output logic                  bit_out,
  output logic [3:0]            digit_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // Pre-correct so the doubled value carries into the next cell
  assign adj       = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out   = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = sidrw_pkg::CODE_ZERO;
    end else if (ctrl.bin_shift) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.dig_shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== rtl/signed_int_to_digit_register_writes.sv =====
// Turns a 16-bit signed value into DIGIT_COUNT digit-register writes (addresses 1..DIGIT_COUNT),
// left-aligned text, minus code 10 for negatives, blank code 15 after the text. A transaction
// passes through the states CONV (bit-serial conversion through the five-cell digit chain),
// ALIGN (drops leading zeros, keeping at least one digit) and EMIT (one write per cycle); busy
// is high in every state but IDLE. Each write sits on the outputs in the cycle after it is
// formed, so the last one appears in the first cycle with busy low. Writes appear for one
// cycle each under out_strobe and cannot be held off by the receiver.
// Depends on sidrw_pkg and sidrw_cell.
module signed_int_to_digit_register_writes #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_signed_value,
  output logic        out_strobe,
  output logic [3:0]  out_digit_address,
  output logic [3:0]  out_digit_code,
  output logic        out_last_write
);

  localparam int unsigned NC = sidrw_pkg::BCD_DIGITS;

  typedef enum logic [1:0] {IDLE, CONV, ALIGN, EMIT} state_t;

  state_t      state_r;
  logic [3:0]  cnt_r;
  logic [3:0]  pos_r;
  logic        neg_r;
  logic [15:0] mag_r;
  logic        strobe_r;
  logic [3:0]  addr_r;
  logic [3:0]  code_r;
  logic        last_r;

  sidrw_pkg::cell_ctrl_t ctrl;
  logic [NC-1:0]         bit_chain;
  logic [3:0]            dig_chain [NC];
  logic [3:0]            top_digit;
  logic                  accept;
  logic                  emit_minus;

  assign accept     = start && (state_r == IDLE);
  assign top_digit  = dig_chain[NC-1];
  assign emit_minus = (pos_r == sidrw_pkg::FIRST_ADDR) && neg_r;

  always_comb begin
    ctrl = '0;
    case (state_r)
      IDLE:  ctrl.clear     = start;
      CONV:  ctrl.bin_shift = 1'b1;
      ALIGN: ctrl.dig_shift = (top_digit == sidrw_pkg::CODE_ZERO) &&
                              (cnt_r != 4'(NC - 1));
      EMIT:  ctrl.dig_shift = !emit_minus;
      default: ctrl = '0;
    endcase
  end

  for (genvar g = 0; g < NC; g++) begin : g_cell
    logic       bin_in;
    logic [3:0] d_in;
    if (g == 0) begin : g_first
      assign bin_in = mag_r[15];
      assign d_in   = sidrw_pkg::CODE_BLANK;
    end else begin : g_rest
      assign bin_in = bit_chain[g-1];
      assign d_in   = dig_chain[g-1];
    end
    sidrw_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (bin_in),
      .digit_in  (d_in),
      .bit_out   (bit_chain[g]),
      .digit_out (dig_chain[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= IDLE;
      cnt_r    <= '0;
      pos_r    <= sidrw_pkg::FIRST_ADDR;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (state_r == EMIT);
      case (state_r)
        IDLE: begin
          if (accept) begin
            neg_r   <= in_signed_value[15];
            mag_r   <= in_signed_value[15] ? (16'd0 - in_signed_value) : in_signed_value;
            cnt_r   <= '0;
            state_r <= CONV;
          end
        end
        CONV: begin
          // the count wraps to zero on the last shift
          mag_r <= {mag_r[14:0], 1'b0};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(sidrw_pkg::VALUE_W - 1)) begin
            state_r <= ALIGN;
          end
        end
        ALIGN: begin
          if (ctrl.dig_shift) begin
            cnt_r <= cnt_r + 4'd1;
          end else begin
            pos_r   <= sidrw_pkg::FIRST_ADDR;
            state_r <= EMIT;
          end
        end
        EMIT: begin
          addr_r   <= pos_r;
          code_r   <= emit_minus ? sidrw_pkg::CODE_MINUS : top_digit;
          last_r   <= (pos_r == 4'(DIGIT_COUNT));
          pos_r    <= pos_r + 4'd1;
          if (pos_r == 4'(DIGIT_COUNT)) begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign busy              = (state_r != IDLE);
  assign out_strobe        = strobe_r;
  assign out_digit_address = addr_r;
  assign out_digit_code    = code_r;
  assign out_last_write    = last_r;

endmodule

// ===== test/tb_signed_int_to_digit_register_writes.sv =====
// Testbench for signed_int_to_digit_register_writes: drives 16-bit signed values
// and checks each run of eight digit-register writes against a local formatter model.
// Depends on sidrw_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_signed_int_to_digit_register_writes;

  localparam int unsigned DIGITS = 8;

  typedef struct packed {
    logic [3:0] address;
    logic [3:0] code;
    logic       last;
  } digit_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_signed_value = '0;
  logic        out_strobe;
  logic [3:0]  out_digit_address;
  logic [3:0]  out_digit_code;
  logic        out_last_write;

  logic [15:0]  pending_values[$];
  digit_write_t digit_writes_due[$];
  int unsigned  values_taken = 0;
  int unsigned  error_count = 0;
  digit_write_t seen_write;
  digit_write_t due_write;

  signed_int_to_digit_register_writes #(.DIGIT_COUNT(DIGITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_signed_value  (in_signed_value),
    .out_strobe       (out_strobe),
    .out_digit_address(out_digit_address),
    .out_digit_code   (out_digit_code),
    .out_last_write   (out_last_write)
  );

  always #1 clk = ~clk;

  // Format one value as left-aligned digit-code text and queue its register writes.
  function automatic void queue_digit_writes(logic [15:0] value);
    logic [16:0]  magnitude;
    logic [3:0]   reversed[5];
    logic [3:0]   text[6];
    int unsigned  digit_total;
    int unsigned  text_len;
    digit_write_t wr;
    magnitude = value[15] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
    digit_total = 0;
    do begin
      reversed[digit_total] = 4'(magnitude % 10);
      digit_total++;
      magnitude = magnitude / 10;
    end while (magnitude != 0 && digit_total < 5);
    text_len = 0;
    if (value[15]) begin
      text[0] = sidrw_pkg::CODE_MINUS;
      text_len = 1;
    end
    for (int i = 0; i < digit_total; i++) begin
      text[text_len] = reversed[digit_total - 1 - i];
      text_len++;
    end
    for (int pos = 0; pos < DIGITS; pos++) begin
      wr.address = sidrw_pkg::FIRST_ADDR + 4'(pos);
      wr.code    = (pos < text_len) ? text[pos] : sidrw_pkg::CODE_BLANK;
      wr.last    = (pos == DIGITS - 1);
      digit_writes_due.push_back(wr);
    end
  endfunction

  // Driver: take a transaction when start meets a low busy, then offer the next value.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        queue_digit_writes(in_signed_value);
        void'(pending_values.pop_front());
        values_taken++;
      end
      // hold off at random, except through one long stretch of back-to-back offers
      if (pending_values.size() != 0 &&
          ((values_taken >= 180 && values_taken < 320) || $urandom_range(0, 99) >= 12)) begin
        start           <= 1'b1;
        in_signed_value <= pending_values[0];
      end else begin
        start           <= 1'b0;
        in_signed_value <= 16'($urandom);
      end
    end
  end

  // Monitor: every strobed write must match the oldest expected write.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      seen_write = '{out_digit_address, out_digit_code, out_last_write};
      if (digit_writes_due.size() == 0) begin
        $display("%0t: unexpected write addr=%0d code=%0d last=%0b", $realtime,
                 out_digit_address, out_digit_code, out_last_write);
        error_count++;
      end else begin
        due_write = digit_writes_due.pop_front();
        if (seen_write !== due_write) begin
          $display("%0t: expected addr=%0d code=%0d last=%0b, got addr=%0d code=%0d last=%0b",
                   $realtime, due_write.address, due_write.code, due_write.last,
                   seen_write.address, seen_write.code, seen_write.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    int          edge_values[];
    int unsigned digit_len;
    int unsigned magnitude;
    logic [15:0] value;

    edge_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -999, 1000, 9999,
                    -10000, 10000, 32767, -32768, -32767, 12345, -12345,
                    16'h5555, -21846, 7, 30000};
    foreach (edge_values[i]) pending_values.push_back(16'(edge_values[i]));
    for (int n = 0; n < 450; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        value = 16'($urandom);
      end else begin
        // pick a bound of one to five digits at random, then a magnitude within it
        digit_len = $urandom_range(1, 5);
        magnitude = $urandom_range(0, (10 ** digit_len) - 1);
        if (magnitude > 32767) magnitude = 32767;
        value = $urandom_range(0, 1) ? 16'(-int'(magnitude)) : 16'(magnitude);
      end
      pending_values.push_back(value);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_values.size() != 0 || digit_writes_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("FAIL");
    $finish;
  end

endmodule
